>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VWD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vibration window detector: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define VWD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vibration window detector: assertion failed");

`endif

>>> sv/vwd_pkg.sv
`default_nettype none

package vwd_pkg;

    localparam int NUM_AXES       = 3;
    localparam int SAMPLE_W       = 16;
    localparam int OUT_SUM_W      = 20;
    localparam int GRAVITY_W      = 15;
    localparam int THRESHOLD_W    = 16;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int WINDOW_DEFAULT = 10;

    localparam logic [GRAVITY_W-1:0]   GRAVITY_RESET   = 15'd4096;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd4177;

    // Register select, taken from byte address bit 2.
    localparam logic [0:0] REG_GRAVITY   = 1'b0;
    localparam logic [0:0] REG_THRESHOLD = 1'b1;

    // Full-precision window sum width.
    function automatic int vwd_sum_w(input int window);
        return SAMPLE_W + $clog2(window);
    endfunction

    // Bits needed to hold the window length itself.
    function automatic int vwd_len_w(input int window);
        return $clog2(window + 1);
    endfunction

    function automatic int vwd_offs_w(input int window);
        return GRAVITY_W + vwd_len_w(window);
    endfunction

    function automatic int vwd_lim_w(input int window);
        return THRESHOLD_W + vwd_len_w(window);
    endfunction

endpackage

`default_nettype wire

>>> sv/vwd_if.sv
`default_nettype none

interface vwd_sample_if;
    import vwd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic signed [SAMPLE_W-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

interface vwd_result_if;
    import vwd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        vibration;
    logic signed [OUT_SUM_W-1:0] window_sum_x;
    logic signed [OUT_SUM_W-1:0] window_sum_y;
    logic signed [OUT_SUM_W-1:0] window_sum_z;

    modport source (output valid, output vibration, output window_sum_x,
                    output window_sum_y, output window_sum_z, input ready);
    modport sink   (input valid, input vibration, input window_sum_x,
                    input window_sum_y, input window_sum_z, output ready);
endinterface

`default_nettype wire

>>> sv/vwd_cfg.sv
`default_nettype none

module vwd_cfg #(
    parameter int WINDOW = vwd_pkg::WINDOW_DEFAULT,
    localparam int OFFS_W = vwd_pkg::vwd_offs_w(WINDOW),
    localparam int LIM_W  = vwd_pkg::vwd_lim_w(WINDOW)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vwd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vwd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vwd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [OFFS_W-1:0]               offset,
    output logic      [LIM_W-1:0]                lim
);
    import vwd_pkg::*;

    logic [GRAVITY_W-1:0]   gravity_reg,   gravity_next;
    logic [THRESHOLD_W-1:0] threshold_reg, threshold_next;
    logic [OFFS_W-1:0]      offset_reg,    offset_next;
    logic [LIM_W-1:0]       lim_reg,       lim_next;
    logic [0:0]             reg_sel;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        gravity_next   = gravity_reg;
        threshold_next = threshold_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_GRAVITY:   gravity_next   = pwdata[GRAVITY_W-1:0];
                REG_THRESHOLD: threshold_next = pwdata[THRESHOLD_W-1:0];
                default:       gravity_next   = gravity_reg;
            endcase
        end
        // Scale by the window length here so the datapath sees sums, not averages.
        offset_next = OFFS_W'(gravity_next) * OFFS_W'(WINDOW);
        lim_next    = LIM_W'(threshold_next) * LIM_W'(WINDOW);
    end

    always_comb
    begin
        case (reg_sel)
            REG_GRAVITY:   prdata = APB_DATA_W'(gravity_reg);
            REG_THRESHOLD: prdata = APB_DATA_W'(threshold_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg   <= GRAVITY_RESET;
            threshold_reg <= THRESHOLD_RESET;
            offset_reg    <= OFFS_W'(GRAVITY_RESET) * OFFS_W'(WINDOW);
            lim_reg       <= LIM_W'(THRESHOLD_RESET) * LIM_W'(WINDOW);
        end
        else
        begin
            gravity_reg   <= gravity_next;
            threshold_reg <= threshold_next;
            offset_reg    <= offset_next;
            lim_reg       <= lim_next;
        end
    end

    assign offset = offset_reg;
    assign lim    = lim_reg;

endmodule

`default_nettype wire

>>> sv/vwd_window.sv
`default_nettype none
`include "assert_macros.svh"

module vwd_window #(
    parameter int WINDOW = vwd_pkg::WINDOW_DEFAULT,
    localparam int SUM_W = vwd_pkg::vwd_sum_w(WINDOW)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    vwd_sample_if.sink              sample,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [SUM_W-1:0]   sums [vwd_pkg::NUM_AXES]
);
    import vwd_pkg::*;

    logic signed [SAMPLE_W-1:0] line_reg [NUM_AXES][WINDOW];
    logic signed [SAMPLE_W-1:0] sample_in [NUM_AXES];
    logic signed [SUM_W-1:0]    sum_reg  [NUM_AXES];
    logic signed [SUM_W-1:0]    sum_next [NUM_AXES];
    logic                       valid_reg, valid_next;
    logic                       accept;

    assign sample_in[0] = sample.sample_x;
    assign sample_in[1] = sample.sample_y;
    assign sample_in[2] = sample.sample_z;

    assign sample.ready = !valid_reg || out_ready;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        // Add the newest sample, drop the one leaving the window.
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_next[a] = sum_reg[a] + SUM_W'(sample_in[a]) - SUM_W'(line_reg[a][WINDOW-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum_reg[a] <= '0;
                for (int i = 0; i < WINDOW; i++)
                begin
                    line_reg[a][i] <= '0;
                end
            end
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sum_reg[a]     <= sum_next[a];
                    line_reg[a][0] <= sample_in[a];
                    for (int i = 1; i < WINDOW; i++)
                    begin
                        line_reg[a][i] <= line_reg[a][i-1];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg;
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sums[a] = sum_reg[a];
        end
    end

    `VWD_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, valid_reg)
    `VWD_ASSERT_NEXT(a_stall_holds, clk, rst_n, valid_reg && !out_ready, valid_reg)
    `VWD_ASSERT_NEXT(a_sums_idle, clk, rst_n, !accept,
                     $stable(sum_reg[0]) && $stable(sum_reg[1]) && $stable(sum_reg[2]))

endmodule

`default_nettype wire

>>> sv/vwd_magnitude.sv
`default_nettype none
`include "assert_macros.svh"

module vwd_magnitude #(
    parameter int WINDOW = vwd_pkg::WINDOW_DEFAULT,
    localparam int SUM_W  = vwd_pkg::vwd_sum_w(WINDOW),
    localparam int OFFS_W = vwd_pkg::vwd_offs_w(WINDOW),
    localparam int LIM_W  = vwd_pkg::vwd_lim_w(WINDOW)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [SUM_W-1:0]   sums [vwd_pkg::NUM_AXES],
    input  wire logic [OFFS_W-1:0]  offset,
    input  wire logic [LIM_W-1:0]   lim,
    vwd_result_if.source            result
);
    import vwd_pkg::*;

    localparam int DZ_W   = ((SUM_W > OFFS_W) ? SUM_W : OFFS_W) + 2;
    localparam int SQ_W   = 2 * DZ_W;
    localparam int MAG_W  = SQ_W + 2;
    localparam int LIM2_W = 2 * LIM_W;
    localparam int CMP_W  = (MAG_W > LIM2_W) ? MAG_W : LIM2_W;
    localparam int EXT_W  = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;

    // Square stage
    logic signed [DZ_W-1:0]      term [NUM_AXES];
    logic signed [SQ_W-1:0]      prod [NUM_AXES];
    logic signed [EXT_W-1:0]     ext  [NUM_AXES];
    logic        [SQ_W-1:0]      sq_reg [NUM_AXES];
    logic        [LIM2_W-1:0]    lim2_reg;
    logic        [OUT_SUM_W-1:0] wsum_reg [NUM_AXES];
    logic                        sq_valid_reg, sq_valid_next;
    logic                        sq_ready;

    // Output stage
    logic [CMP_W-1:0]     mag;
    logic                 vib_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 vib_reg;
    logic [OUT_SUM_W-1:0] out_sum_reg [NUM_AXES];
    logic                 out_ready;

    assign out_ready = !out_valid_reg || result.ready;
    assign sq_ready  = !sq_valid_reg || out_ready;
    assign in_ready  = sq_ready;

    always_comb
    begin
        term[0] = DZ_W'($signed(sums[0]));
        term[1] = DZ_W'($signed(sums[1]));
        // Take one g per sample off the Z sum.
        term[2] = DZ_W'($signed(sums[2])) - $signed(DZ_W'(offset));
        for (int a = 0; a < NUM_AXES; a++)
        begin
            prod[a] = term[a] * term[a];
            ext[a]  = EXT_W'($signed(sums[a]));
        end
        sq_valid_next = sq_ready ? in_valid : sq_valid_reg;
    end

    always_comb
    begin
        mag = CMP_W'(sq_reg[0]) + CMP_W'(sq_reg[1]) + CMP_W'(sq_reg[2]);
        vib_next = mag > CMP_W'(lim2_reg);
        out_valid_next = out_ready ? sq_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg  <= sq_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && sq_ready)
        begin
            lim2_reg <= LIM2_W'(lim) * LIM2_W'(lim);
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sq_reg[a]   <= SQ_W'(prod[a]);
                wsum_reg[a] <= ext[a][OUT_SUM_W-1:0];
            end
        end
        if (sq_valid_reg && out_ready)
        begin
            vib_reg <= vib_next;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                out_sum_reg[a] <= wsum_reg[a];
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.vibration    = vib_reg;
    assign result.window_sum_x = out_sum_reg[0];
    assign result.window_sum_y = out_sum_reg[1];
    assign result.window_sum_z = out_sum_reg[2];

    `VWD_ASSERT_NEXT(a_sq_stall_holds, clk, rst_n, sq_valid_reg && !out_ready, sq_valid_reg)
    `VWD_ASSERT_NEXT(a_sq_moves_on, clk, rst_n, sq_valid_reg && out_ready, out_valid_reg)
    `VWD_ASSERT_NEXT(a_zero_is_quiet, clk, rst_n,
                     sq_valid_reg && out_ready && sq_reg[0] == '0 && sq_reg[1] == '0
                     && sq_reg[2] == '0, !vib_reg)

endmodule

`default_nettype wire

>>> sv/vibration_window_detector.sv
// Vibration window detector.
// sample (sink): one three-axis accelerometer sample per request, signed raw counts.
// result (source): per sample, the vibration flag and the three window sums
//   (sum of the last WINDOW samples of each axis, low 20 bits, two's complement).
// APB port: register 0 at byte 0 holds one g in counts, register 1 at byte 4 the
//   magnitude threshold; write only while no sample is in flight. pready is tied high.
// Flag test: Sx^2 + Sy^2 + (Sz - WINDOW*g)^2 > (WINDOW*threshold)^2, exact.
// Path: from sample acceptance to result valid, the request passes the window sum
//   register (loaded at the accepting edge), square register, output register.
// Throughput: one sample per cycle while result.ready is high; the three squarers
//   run in parallel and the shift lines move once per accepted sample, so nothing iterates.
// Stall: with result.ready low, up to three samples are held in the pipeline and
//   sample.ready falls only when all three stages are full.
// Reset: sample history and window sums clear to zero (warm-up sums count missing
//   samples as zero), registers return to 4096 and 4177, pipeline empties.
`default_nettype none

module vibration_window_detector #(
    parameter int WINDOW = vwd_pkg::WINDOW_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vwd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [vwd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [vwd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    vwd_sample_if.sink                           sample,
    vwd_result_if.source                         result
);
    import vwd_pkg::*;

    localparam int SUM_W  = vwd_sum_w(WINDOW);
    localparam int OFFS_W = vwd_offs_w(WINDOW);
    localparam int LIM_W  = vwd_lim_w(WINDOW);

    logic [OFFS_W-1:0] offset;
    logic [LIM_W-1:0]  lim;
    logic              mid_valid;
    logic              mid_ready;
    logic [SUM_W-1:0]  mid_sums [NUM_AXES];

    vwd_cfg #(.WINDOW(WINDOW)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .offset  (offset),
        .lim     (lim)
    );

    vwd_window #(.WINDOW(WINDOW)) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .sums      (mid_sums)
    );

    vwd_magnitude #(.WINDOW(WINDOW)) u_magnitude (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .sums     (mid_sums),
        .offset   (offset),
        .lim      (lim),
        .result   (result)
    );

endmodule

`default_nettype wire
